// File: hdl/cdbq_pkg.sv
`default_nettype none

package cdbq_pkg;

	localparam int CURVE_ENTRIES_DEF = 65536;
	localparam int SAMPLE_BITS_DEF   = 18;

	localparam int DEPTH_BITS_MIN = 12;
	localparam int DEPTH_BITS_MAX = 16;

	// widths of the log-domain values
	localparam int VAL_BITS  = 16;
	localparam int DIFF_BITS = VAL_BITS + 1;
	localparam int SUM_BITS  = VAL_BITS + 3;
	localparam int LANES     = 4;

	// lane order inside the pipeline
	localparam int LANE_R  = 0;
	localparam int LANE_B  = 1;
	localparam int LANE_G1 = 2;
	localparam int LANE_G2 = 3;

	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEPTH_BITS = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_IS_RGGB    = 1'd1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_TABLE = 1'b1;

	typedef struct packed {
		logic [4:0] depth_bits;
		logic       is_rggb;
	} cfg_t;

	typedef struct packed {
		logic                        req_type;
		logic [VAL_BITS-1:0]         table_addr;
		logic [VAL_BITS-1:0]         table_data;
		logic [VAL_BITS-1:0]         gs;
		logic signed [DIFF_BITS-1:0] rg;
		logic signed [DIFF_BITS-1:0] bg;
		logic signed [DIFF_BITS-1:0] gd;
	} item_s1_t;

	typedef struct packed {
		logic                            req_type;
		logic [VAL_BITS-1:0]             table_addr;
		logic [VAL_BITS-1:0]             table_data;
		logic [LANES-1:0][VAL_BITS-1:0]  idx;
	} item_s2_t;

	typedef struct packed {
		logic [LANES-1:0][VAL_BITS-1:0] entry;
		logic [LANES-1:0]               oob;
	} look_s3_t;

	function automatic logic [VAL_BITS-1:0] curve_max(input logic [4:0] lb);
		return VAL_BITS'((17'd1 << lb) - 17'd1);
	endfunction

	function automatic logic [VAL_BITS-1:0] curve_mid(input logic [4:0] lb);
		return VAL_BITS'(17'd1 << (lb - 5'd1));
	endfunction

endpackage

`default_nettype wire

// File: hdl/cdbq_ram.sv
`default_nettype none

module cdbq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic      [WIDTH-1:0]         rd_data_a,
	output logic      [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

// File: hdl/cdbq_unpack.sv
`default_nettype none

module cdbq_unpack
	import cdbq_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire cfg_t                   cfg,
	input  wire logic                   req_type,
	input  wire logic [VAL_BITS-1:0]    table_addr,
	input  wire logic [VAL_BITS-1:0]    table_data,
	input  wire logic [SAMPLE_BITS-1:0] gs_value,
	input  wire logic [SAMPLE_BITS-1:0] rg_value,
	input  wire logic [SAMPLE_BITS-1:0] bg_value,
	input  wire logic [SAMPLE_BITS-1:0] gd_value,
	output item_s1_t                    item_s1
);

	function automatic logic [VAL_BITS-1:0] clamp_in(
		input logic [SAMPLE_BITS-1:0] v,
		input logic [VAL_BITS-1:0]    maxv
	);
		// negative samples floor at zero
		if (v[SAMPLE_BITS-1]) begin
			return '0;
		end else if (v[SAMPLE_BITS-2:0] > (SAMPLE_BITS-1)'(maxv)) begin
			return maxv;
		end else begin
			return v[VAL_BITS-1:0];
		end
	endfunction

	logic [VAL_BITS-1:0]         maxv;
	logic [VAL_BITS-1:0]         mid;
	logic signed [DIFF_BITS-1:0] mid_s;
	item_s1_t                    nxt;

	always_comb begin
		maxv  = curve_max(cfg.depth_bits);
		mid   = curve_mid(cfg.depth_bits);
		mid_s = $signed({1'b0, mid});
		nxt.req_type   = req_type;
		nxt.table_addr = table_addr;
		nxt.table_data = table_data;
		nxt.gs = clamp_in(gs_value, maxv);
		nxt.rg = $signed({1'b0, clamp_in(rg_value, maxv)}) - mid_s;
		nxt.bg = $signed({1'b0, clamp_in(bg_value, maxv)}) - mid_s;
		nxt.gd = $signed({1'b0, clamp_in(gd_value, maxv)}) - mid_s;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

`default_nettype wire

// File: hdl/cdbq_mix.sv
`default_nettype none

module cdbq_mix
	import cdbq_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     en,
	input  wire cfg_t     cfg,
	input  wire item_s1_t item_s1,
	output item_s2_t      item_s2
);

	function automatic logic [VAL_BITS-1:0] clamp_sum(
		input logic signed [SUM_BITS-1:0] v,
		input logic [VAL_BITS-1:0]        maxv
	);
		if (v < 0) begin
			return '0;
		end else if (v > $signed({3'b000, maxv})) begin
			return maxv;
		end else begin
			return v[VAL_BITS-1:0];
		end
	endfunction

	logic [VAL_BITS-1:0]        maxv;
	logic signed [SUM_BITS-1:0] gs_w;
	logic signed [SUM_BITS-1:0] rg_w;
	logic signed [SUM_BITS-1:0] bg_w;
	logic signed [SUM_BITS-1:0] gd_w;
	item_s2_t                   nxt;

	always_comb begin
		maxv = curve_max(cfg.depth_bits);
		gs_w = $signed({3'b000, item_s1.gs});
		rg_w = SUM_BITS'(item_s1.rg);
		bg_w = SUM_BITS'(item_s1.bg);
		gd_w = SUM_BITS'(item_s1.gd);
		nxt.req_type   = item_s1.req_type;
		nxt.table_addr = item_s1.table_addr;
		nxt.table_data = item_s1.table_data;
		nxt.idx[LANE_R]  = clamp_sum((rg_w <<< 1) + gs_w, maxv);
		nxt.idx[LANE_B]  = clamp_sum((bg_w <<< 1) + gs_w, maxv);
		nxt.idx[LANE_G1] = clamp_sum(gs_w + gd_w, maxv);
		nxt.idx[LANE_G2] = clamp_sum(gs_w - gd_w, maxv);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2 <= nxt;
		end
	end

endmodule

`default_nettype wire

// File: hdl/cdbq_lookup.sv
`default_nettype none

module cdbq_lookup
	import cdbq_pkg::*;
#(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF
) (
	input  wire logic     clk,
	input  wire logic     en,
	input  wire logic     valid_s2,
	input  wire item_s2_t item_s2,
	output look_s3_t      look_s3
);

	localparam int ADDR_BITS = $clog2(CURVE_ENTRIES);

	logic             wr_en;
	logic [LANES-1:0] oob;
	logic [LANES-1:0] oob_s3;
	logic [LANES-1:0][VAL_BITS-1:0] entry;

	// table writes land in both copies so every lane sees the same curve
	assign wr_en = en && valid_s2 && (item_s2.req_type == REQ_TABLE) &&
		(32'(item_s2.table_addr) < CURVE_ENTRIES);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			oob[i] = 32'(item_s2.idx[i]) >= CURVE_ENTRIES;
		end
	end

	cdbq_ram #(
		.WIDTH(VAL_BITS),
		.DEPTH(CURVE_ENTRIES)
	) u_ram_rb (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (item_s2.table_addr[ADDR_BITS-1:0]),
		.wr_data  (item_s2.table_data),
		.rd_en    (en),
		.rd_addr_a(item_s2.idx[LANE_R][ADDR_BITS-1:0]),
		.rd_addr_b(item_s2.idx[LANE_B][ADDR_BITS-1:0]),
		.rd_data_a(entry[LANE_R]),
		.rd_data_b(entry[LANE_B])
	);

	cdbq_ram #(
		.WIDTH(VAL_BITS),
		.DEPTH(CURVE_ENTRIES)
	) u_ram_g (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (item_s2.table_addr[ADDR_BITS-1:0]),
		.wr_data  (item_s2.table_data),
		.rd_en    (en),
		.rd_addr_a(item_s2.idx[LANE_G1][ADDR_BITS-1:0]),
		.rd_addr_b(item_s2.idx[LANE_G2][ADDR_BITS-1:0]),
		.rd_data_a(entry[LANE_G1]),
		.rd_data_b(entry[LANE_G2])
	);

	always_ff @(posedge clk) begin
		if (en) begin
			oob_s3 <= oob;
		end
	end

	assign look_s3.entry = entry;
	assign look_s3.oob   = oob_s3;

endmodule

`default_nettype wire

// File: hdl/color_difference_to_bayer_quad_core.sv
`default_nettype none

// Converts one pixel of luma-sum / color-difference samples into a 2x2 Bayer
// quad (RGGB or GBRG) through a loaded inverse-log curve. Requests with
// req_type set write one curve entry and give no result; pixel requests give
// one quad. One request is taken per clock while req_stall is low; a pixel
// result passes registered clamp and center, mix and clamp, curve read, and
// shift and order stages. Throughput comes from two copies of the curve
// memory, each with two read ports, so all four lanes read in the same cycle.
// Curve entries are undefined until written and there is no clearing pass.
// The stored bit depth is saturated into 12..16 on use. Configure only
// while the block is idle.
module color_difference_to_bayer_quad_core
	import cdbq_pkg::*;
#(
	parameter int CURVE_ENTRIES = CURVE_ENTRIES_DEF,
	parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wr_en,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  wire logic                      req_valid,
	output logic                           req_stall,
	input  wire logic                      req_type,
	input  wire logic [VAL_BITS-1:0]       table_addr,
	input  wire logic [VAL_BITS-1:0]       table_data,
	input  wire logic [SAMPLE_BITS-1:0]    gs_value,
	input  wire logic [SAMPLE_BITS-1:0]    rg_value,
	input  wire logic [SAMPLE_BITS-1:0]    bg_value,
	input  wire logic [SAMPLE_BITS-1:0]    gd_value,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic [VAL_BITS-1:0]            top_left,
	output logic [VAL_BITS-1:0]            top_right,
	output logic [VAL_BITS-1:0]            bottom_left,
	output logic [VAL_BITS-1:0]            bottom_right
);

	logic [4:0] depth_bits_q;
	logic       is_rggb_q;
	cfg_t       cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_bits_q <= 5'(DEPTH_BITS_MIN);
			is_rggb_q    <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_DEPTH_BITS: depth_bits_q <= cfg_data;
				REG_IS_RGGB:    is_rggb_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (depth_bits_q < 5'(DEPTH_BITS_MIN)) begin
			cfg.depth_bits = 5'(DEPTH_BITS_MIN);
		end else if (depth_bits_q > 5'(DEPTH_BITS_MAX)) begin
			cfg.depth_bits = 5'(DEPTH_BITS_MAX);
		end else begin
			cfg.depth_bits = depth_bits_q;
		end
		cfg.is_rggb = is_rggb_q;
	end

	item_s1_t item_s1;
	item_s2_t item_s2;
	look_s3_t look_s3;

	// per-stage advance, bubbles collapse so an empty stage fills even while a result waits
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic adv1;
	logic adv2;
	logic adv3;
	logic adv4;

	assign adv4      = !valid_s4 || !res_stall;
	assign adv3      = !valid_s3 || adv4;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign req_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= req_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
			// table writes retire at the curve memory
			if (adv3) begin
				valid_s3 <= valid_s2 && (item_s2.req_type == REQ_PIXEL);
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	cdbq_unpack #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_unpack (
		.clk       (clk),
		.en        (adv1),
		.cfg       (cfg),
		.req_type  (req_type),
		.table_addr(table_addr),
		.table_data(table_data),
		.gs_value  (gs_value),
		.rg_value  (rg_value),
		.bg_value  (bg_value),
		.gd_value  (gd_value),
		.item_s1   (item_s1)
	);

	cdbq_mix u_mix (
		.clk    (clk),
		.en     (adv2),
		.cfg    (cfg),
		.item_s1(item_s1),
		.item_s2(item_s2)
	);

	cdbq_lookup #(
		.CURVE_ENTRIES(CURVE_ENTRIES)
	) u_lookup (
		.clk     (clk),
		.en      (adv3),
		.valid_s2(valid_s2),
		.item_s2 (item_s2),
		.look_s3 (look_s3)
	);

	logic [2:0]                     shift;
	logic [LANES-1:0][VAL_BITS-1:0] lin;
	logic [LANES-1:0][VAL_BITS-1:0] quad;

	assign shift = 3'(5'(VAL_BITS) - cfg.depth_bits);

	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			lin[i] = look_s3.oob[i] ? '0 : (look_s3.entry[i] >> shift);
		end
		if (cfg.is_rggb) begin
			quad[0] = lin[LANE_R];
			quad[1] = lin[LANE_G1];
			quad[2] = lin[LANE_G2];
			quad[3] = lin[LANE_B];
		end else begin
			quad[0] = lin[LANE_G1];
			quad[1] = lin[LANE_B];
			quad[2] = lin[LANE_R];
			quad[3] = lin[LANE_G2];
		end
	end

	logic [LANES-1:0][VAL_BITS-1:0] quad_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			quad_s4 <= quad;
		end
	end

	assign res_valid    = valid_s4;
	assign top_left     = quad_s4[0];
	assign top_right    = quad_s4[1];
	assign bottom_left  = quad_s4[2];
	assign bottom_right = quad_s4[3];

endmodule

`default_nettype wire
